>>> rtl/qks_pkg.sv
// Shared types and constants for the quaternion keyframe sampler.
// Used by every module in rtl/; depends on nothing.
package qks_pkg;

  localparam int DEF_MAX_KEYS = 8;

  // Q32.32 one and the rounding half of one LSB of the integer part.
  localparam logic [63:0] ONE_Q  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] HALF_Q = 64'h0000_0000_8000_0000;

  // Shift/subtract unit sizing.
  localparam int DIV_N_W    = 98;
  localparam int DIV_D_W    = 66;
  localparam int REM_W      = 68;
  localparam int ROOT_W     = 49;
  localparam int STEP_W     = 7;
  localparam int DIV_STEPS  = DIV_N_W;
  localparam int SQRT_STEPS = DIV_N_W / 2;

  // Signed accumulator width for sums of four 128-bit products.
  localparam int ACC_W = 131;

  // Numerator of the reciprocal norm, 2^96.
  localparam logic [DIV_N_W-1:0] RECIP_NUM = DIV_N_W'(1) << 96;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 4'd1;

  // Item opcodes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [2:0]        key_index;
    logic signed [63:0] key_time;
    logic signed [63:0] key_w;
    logic signed [63:0] key_x;
    logic signed [63:0] key_y;
    logic signed [63:0] key_z;
    logic signed [63:0] sample_time;
  } qks_in_t;

  typedef struct packed {
    logic signed [63:0] rot_w;
    logic signed [63:0] rot_x;
    logic signed [63:0] rot_y;
    logic signed [63:0] rot_z;
    logic               refused;
  } qks_out_t;

  typedef struct packed {
    logic signed [63:0] w;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } qks_quat_t;

  // Command to the shift/subtract unit.
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } qks_su_cmd_t;

  // Result of a divide-by-one rounding step.
  typedef struct packed {
    logic               ovf;
    logic signed [63:0] val;
  } qks_rnd_t;

endpackage

>>> rtl/qks_shsub.sv
// Shared shift/subtract unit: restoring divider and bitwise integer square root.
// Depends on qks_pkg.
module qks_shsub (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qks_pkg::qks_su_cmd_t          cmd,
  input  logic [qks_pkg::DIV_N_W-1:0]   num,
  input  logic [qks_pkg::DIV_D_W-1:0]   den,
  output logic                          done,
  output logic [qks_pkg::DIV_N_W-1:0]   quo,
  output logic [qks_pkg::REM_W-1:0]     rem,
  output logic [qks_pkg::ROOT_W-1:0]    root
);
  import qks_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic               mode_r;
  logic [STEP_W-1:0]  cnt_r;
  logic [DIV_D_W-1:0] den_r;
  logic [REM_W-1:0]   rem_r;
  logic [DIV_N_W-1:0] quo_r;
  logic [ROOT_W-1:0]  root_r;

  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   sub_op;
  logic [REM_W:0]     diff;
  logic               take;

  // Division brings in one numerator bit per step, the root two radicand bits.
  always_comb begin
    if (mode_r) begin
      rem_sh = {rem_r[REM_W-3:0], quo_r[DIV_N_W-1 -: 2]};
      sub_op = REM_W'({root_r, 2'b01});
    end else begin
      rem_sh = {rem_r[REM_W-2:0], quo_r[DIV_N_W-1]};
      sub_op = REM_W'(den_r);
    end
    diff = {1'b0, rem_sh} - {1'b0, sub_op};
    take = ~diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= cmd.sqrt_mode;
      cnt_r  <= cmd.sqrt_mode ? STEP_W'(SQRT_STEPS - 1) : STEP_W'(DIV_STEPS - 1);
      den_r  <= den;
      quo_r  <= num;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[REM_W-1:0] : rem_sh;
      cnt_r <= cnt_r - STEP_W'(1);
      if (mode_r) begin
        quo_r  <= {quo_r[DIV_N_W-3:0], 2'b00};
        root_r <= {root_r[ROOT_W-2:0], take};
      end else begin
        quo_r <= {quo_r[DIV_N_W-2:0], take};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
  assign root = root_r;

endmodule

>>> rtl/qks_mul.sv
// Iterative 64 x 64 unsigned multiplier built from one 32 x 32 multiplier.
// Depends on qks_pkg.
module qks_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  import qks_pkg::*;

  logic         busy_r;
  logic         done_r;
  logic [1:0]   k_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [127:0] acc_r;

  logic [31:0]  a_h;
  logic [31:0]  b_h;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  // Partial product k: bit 1 picks the half of a, bit 0 the half of b.
  always_comb begin
    a_h = k_r[1] ? a_r[63:32] : a_r[31:0];
    b_h = k_r[0] ? b_r[63:32] : b_r[31:0];
    pp  = 64'(a_h) * 64'(b_h);
    unique case (k_r)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && k_r == 2'd3) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      k_r   <= 2'd0;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
      k_r   <= k_r + 2'd1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> rtl/qks_keystore.sv
// Keyframe storage: one time word and one quaternion row per slot.
// Depends on qks_pkg.
module qks_keystore #(
  parameter int MAX_KEYS = qks_pkg::DEF_MAX_KEYS,
  parameter int KW       = $clog2(MAX_KEYS)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [KW-1:0]       wr_addr,
  input  logic signed [63:0]  wr_time,
  input  qks_pkg::qks_quat_t  wr_rot,
  input  logic [KW-1:0]       rd_addr,
  output logic signed [63:0]  rd_time,
  output qks_pkg::qks_quat_t  rd_rot
);
  import qks_pkg::*;

  logic signed [63:0] time_mem [MAX_KEYS];
  qks_quat_t          rot_mem  [MAX_KEYS];
  logic signed [63:0] rd_time_r;
  qks_quat_t          rd_rot_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= wr_time;
      rot_mem[wr_addr]  <= wr_rot;
    end
    rd_time_r <= time_mem[rd_addr];
    rd_rot_r  <= rot_mem[rd_addr];
  end

  assign rd_time = rd_time_r;
  assign rd_rot  = rd_rot_r;

endmodule

>>> rtl/quaternion_keyframe_sampler.sv
// Quaternion keyframe sampler, top level: sequencer, datapath registers and ports.
// Depends on qks_pkg, qks_keystore, qks_shsub and qks_mul.
//
// The block holds one rotation track of up to MAX_KEYS keyframes and samples it.
// A load item writes one keyframe into the key store and gives no result; a slot
// index at or above MAX_KEYS is ignored. A sample item gives exactly one result:
// a unit quaternion in Q32.32 found by an upper-bound binary search over the key
// times, a rounded fraction between the two surrounding keys, and a normalized
// lerp on the shorter arc, scaled by floor(sqrt(2^96 / |b|^2)). When the sample
// is refused (time outside the track, degenerate span, zero norm, a fraction
// outside [0, 1] or a quotient or rounded result that does not fit in 64 bits)
// the result carries refused set and all four components zero. A sample that
// is refused early skips the remaining steps. It uses the shared shift/subtract
// unit for up to three 98-step divisions (the loop wrap, the fraction and the
// reciprocal norm) and one 49-step square root, the multiplier for 20 products
// and the key memory read port for each binary search step. The input is
// stalled for the whole sample. A finished result waits in the output register,
// so the next item is taken while the result is still waiting for its transfer.
// Configuration writes are always ready and must only be issued while the block
// is idle; key_count is clamped to [2, MAX_KEYS]. Slots never loaded read as
// undefined data.
module quaternion_keyframe_sampler #(
  parameter int MAX_KEYS = qks_pkg::DEF_MAX_KEYS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  qks_pkg::qks_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output qks_pkg::qks_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qks_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qks_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import qks_pkg::*;

  localparam int KW    = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int NST   = 27;

  typedef enum logic [NST-1:0] {
    S_IDLE  = NST'(1) << 0,
    S_RD0   = NST'(1) << 1,
    S_RDK   = NST'(1) << 2,
    S_RANGE = NST'(1) << 3,
    S_MOD   = NST'(1) << 4,
    S_SRCH  = NST'(1) << 5,
    S_SCMP  = NST'(1) << 6,
    S_RDI1  = NST'(1) << 7,
    S_FRAC  = NST'(1) << 8,
    S_FRACW = NST'(1) << 9,
    S_DOT   = NST'(1) << 10,
    S_DOTW  = NST'(1) << 11,
    S_DOTF  = NST'(1) << 12,
    S_BLA   = NST'(1) << 13,
    S_BLAW  = NST'(1) << 14,
    S_BLB   = NST'(1) << 15,
    S_BLBW  = NST'(1) << 16,
    S_BLF   = NST'(1) << 17,
    S_NRM   = NST'(1) << 18,
    S_NRMW  = NST'(1) << 19,
    S_NRMF  = NST'(1) << 20,
    S_RCPW  = NST'(1) << 21,
    S_SQW   = NST'(1) << 22,
    S_SCL   = NST'(1) << 23,
    S_SCLW  = NST'(1) << 24,
    S_SCLF  = NST'(1) << 25,
    S_OUT   = NST'(1) << 26
  } qks_state_t;

  // Magnitude of a signed 64-bit value; the most negative value maps to 2^63.
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return m;
  endfunction

  function automatic logic signed [63:0] comp(input qks_quat_t q, input logic [1:0] c);
    logic signed [63:0] v;
    unique case (c)
      2'd0:    v = q.w;
      2'd1:    v = q.x;
      2'd2:    v = q.y;
      default: v = q.z;
    endcase
    return v;
  endfunction

  // Divide by one in Q32.32 with rounding half away from zero.
  function automatic qks_rnd_t round_one(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-1:0]  mag;
    logic [ACC_W-1:0]  sum;
    logic [ACC_W-33:0] qv;
    qks_rnd_t          r;
    mag   = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    sum   = mag + ACC_W'(HALF_Q);
    qv    = sum[ACC_W-1:32];
    r.ovf = |qv[ACC_W-33:63];
    r.val = a[ACC_W-1] ? -$signed(qv[63:0]) : $signed(qv[63:0]);
    return r;
  endfunction

  // Configuration registers.
  logic [3:0] key_count_r;
  logic       loop_en_r;

  // Sequencer and datapath registers.
  qks_state_t               state_r, state_nxt;
  logic [1:0]               c_r, c_nxt;
  logic signed [63:0]       t_r, t_nxt;
  logic signed [63:0]       t0_r, t0_nxt;
  logic signed [63:0]       lt_r, lt_nxt;
  logic signed [63:0]       ti_r, ti_nxt;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hi_r, hi_nxt;
  logic [CNT_W-1:0]         mid_r, mid_nxt;
  logic [KW-1:0]            i_r, i_nxt;
  qks_quat_t                p_r, p_nxt;
  qks_quat_t                q_r, q_nxt;
  logic                     flip_r, flip_nxt;
  logic                     fneg_r, fneg_nxt;
  logic [32:0]              u_r, u_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [63:0]       b_r [4];
  logic signed [63:0]       b_nxt [4];
  logic [ROOT_W-1:0]        r_r, r_nxt;
  logic signed [63:0]       res_r [4];
  logic signed [63:0]       res_nxt [4];
  logic                     ref_r, ref_nxt;

  // Output register.
  logic     out_valid_r;
  qks_out_t out_data_r;
  logic     out_load;

  // Key store.
  logic               wr_en;
  logic [KW-1:0]      rd_addr;
  logic signed [63:0] rd_time;
  qks_quat_t          rd_rot;

  // Shared shift/subtract unit.
  qks_su_cmd_t        su_cmd;
  logic [DIV_N_W-1:0] su_num;
  logic [DIV_D_W-1:0] su_den;
  logic               su_done;
  logic [DIV_N_W-1:0] su_quo;
  logic [REM_W-1:0]   su_rem;
  logic [ROOT_W-1:0]  su_root;

  // Multiplier.
  logic         mul_start;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_done;
  logic [127:0] mul_prod;
  logic         mul_neg;

  // Helpers.
  logic               in_acc;
  logic [CNT_W-1:0]   n_sat;
  logic [CNT_W-1:0]   n_m1;
  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   i_full;
  logic [63:0]        delta;
  logic [63:0]        span;
  logic signed [64:0] p65;
  logic signed [64:0] d65;
  logic [64:0]        pm;
  logic [64:0]        dm;
  logic [32:0]        li;
  logic signed [ACC_W-1:0] prod_s;
  qks_rnd_t           rnd;
  logic signed [63:0] pc;
  logic signed [63:0] qc;
  logic signed [63:0] bc;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_en     = in_acc && (in_data.op == OP_LOAD) && (int'(in_data.key_index) < MAX_KEYS);

  // The track length used by a sample is clamped to at least 2 and at most the table size.
  always_comb begin
    if (key_count_r < 4'd2) begin
      n_sat = CNT_W'(2);
    end else if (int'(key_count_r) > MAX_KEYS) begin
      n_sat = CNT_W'(MAX_KEYS);
    end else begin
      n_sat = CNT_W'(key_count_r);
    end
    n_m1    = n_sat - CNT_W'(1);
    mid_sum = (CNT_W + 1)'(lo_r) + (CNT_W + 1)'(hi_r);
    mid     = mid_sum[CNT_W:1];
    // Left key of the pair: the last key at or before the time, kept inside the track.
    i_full  = (lo_r == '0) ? '0 : lo_r - CNT_W'(1);
    if (i_full >= n_m1) begin
      i_full = n_sat - CNT_W'(2);
    end
  end

  always_comb begin
    delta  = 64'(t_r - t0_r);
    span   = 64'(rd_time - t0_r);
    p65    = {lt_r[63], lt_r} - {ti_r[63], ti_r};
    d65    = {rd_time[63], rd_time} - {ti_r[63], ti_r};
    pm     = p65[64] ? 65'(-p65) : 65'(p65);
    dm     = d65[64] ? 65'(-d65) : 65'(d65);
    li     = 33'(ONE_Q) - u_r;
    pc     = comp(p_r, c_r);
    qc     = comp(q_r, c_r);
    bc     = b_r[c_r];
    rnd    = round_one(acc_r);
    prod_s = mul_neg ? -$signed(ACC_W'(mul_prod)) : $signed(ACC_W'(mul_prod));
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    t_nxt     = t_r;
    t0_nxt    = t0_r;
    lt_nxt    = lt_r;
    ti_nxt    = ti_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    i_nxt     = i_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    flip_nxt  = flip_r;
    fneg_nxt  = fneg_r;
    u_nxt     = u_r;
    acc_nxt   = acc_r;
    b_nxt     = b_r;
    r_nxt     = r_r;
    res_nxt   = res_r;
    ref_nxt   = ref_r;
    rd_addr   = '0;
    su_cmd    = '0;
    su_num    = '0;
    su_den    = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_neg   = 1'b0;
    out_load  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.op == OP_SAMPLE) begin
          t_nxt     = in_data.sample_time;
          ref_nxt   = 1'b0;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        rd_addr   = '0;
        state_nxt = S_RDK;
      end
      S_RDK: begin
        rd_addr   = n_m1[KW-1:0];
        t0_nxt    = rd_time;
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        // rd_time holds the last key time here.
        lo_nxt = '0;
        hi_nxt = n_sat;
        if (t_r < t0_r) begin
          ref_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else if (loop_en_r) begin
          if (rd_time <= t0_r) begin
            ref_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            su_cmd.start = 1'b1;
            su_num       = DIV_N_W'(delta);
            su_den       = DIV_D_W'(span);
            state_nxt    = S_MOD;
          end
        end else if (t_r > rd_time) begin
          ref_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          lt_nxt    = t_r;
          state_nxt = S_SRCH;
        end
      end
      S_MOD: begin
        if (su_done) begin
          lt_nxt    = t0_r + $signed(su_rem[63:0]);
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          rd_addr   = mid[KW-1:0];
          mid_nxt   = mid;
          state_nxt = S_SCMP;
        end else begin
          rd_addr   = i_full[KW-1:0];
          i_nxt     = i_full[KW-1:0];
          state_nxt = S_RDI1;
        end
      end
      S_SCMP: begin
        if (rd_time <= lt_r) begin
          lo_nxt = mid_r + CNT_W'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end
      S_RDI1: begin
        rd_addr   = i_r + KW'(1);
        ti_nxt    = rd_time;
        p_nxt     = rd_rot;
        state_nxt = S_FRAC;
      end
      S_FRAC: begin
        // Fraction numerator (lt - ti) * 2^32 over the key span, rounded.
        q_nxt    = rd_rot;
        fneg_nxt = p65[64] ^ d65[64];
        if (dm == '0) begin
          ref_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          su_cmd.start = 1'b1;
          su_num       = {pm, 33'b0} + DIV_N_W'(dm);
          su_den       = {dm, 1'b0};
          state_nxt    = S_FRACW;
        end
      end
      S_FRACW: begin
        if (su_done) begin
          if (|su_quo[DIV_N_W-1:63]) begin
            ref_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else if (fneg_r && su_quo != '0) begin
            ref_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else if (su_quo[63:0] > ONE_Q) begin
            ref_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            u_nxt     = su_quo[32:0];
            acc_nxt   = '0;
            c_nxt     = 2'd0;
            state_nxt = S_DOT;
          end
        end
      end
      S_DOT: begin
        mul_start = 1'b1;
        mul_a     = mag64(pc);
        mul_b     = mag64(qc);
        state_nxt = S_DOTW;
      end
      S_DOTW: begin
        mul_neg = pc[63] ^ qc[63];
        if (mul_done) begin
          acc_nxt = acc_r + prod_s;
          c_nxt   = c_r + 2'd1;
          state_nxt = (c_r == 2'd3) ? S_DOTF : S_DOT;
        end
      end
      S_DOTF: begin
        // A negative dot product takes the far key negated: shorter arc.
        if (rnd.ovf) begin
          ref_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          flip_nxt  = rnd.val[63];
          c_nxt     = 2'd0;
          state_nxt = S_BLA;
        end
      end
      S_BLA: begin
        mul_start = 1'b1;
        mul_a     = mag64(pc);
        mul_b     = 64'(li);
        state_nxt = S_BLAW;
      end
      S_BLAW: begin
        mul_neg = pc[63];
        if (mul_done) begin
          acc_nxt   = prod_s;
          state_nxt = S_BLB;
        end
      end
      S_BLB: begin
        mul_start = 1'b1;
        mul_a     = mag64(qc);
        mul_b     = 64'(u_r);
        state_nxt = S_BLBW;
      end
      S_BLBW: begin
        mul_neg = qc[63] ^ flip_r;
        if (mul_done) begin
          acc_nxt   = acc_r + prod_s;
          state_nxt = S_BLF;
        end
      end
      S_BLF: begin
        if (rnd.ovf) begin
          ref_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          b_nxt[c_r] = rnd.val;
          c_nxt      = c_r + 2'd1;
          if (c_r == 2'd3) begin
            acc_nxt   = '0;
            state_nxt = S_NRM;
          end else begin
            state_nxt = S_BLA;
          end
        end
      end
      S_NRM: begin
        mul_start = 1'b1;
        mul_a     = mag64(bc);
        mul_b     = mag64(bc);
        state_nxt = S_NRMW;
      end
      S_NRMW: begin
        if (mul_done) begin
          acc_nxt   = acc_r + prod_s;
          c_nxt     = c_r + 2'd1;
          state_nxt = (c_r == 2'd3) ? S_NRMF : S_NRM;
        end
      end
      S_NRMF: begin
        if (rnd.ovf || rnd.val <= 64'sd0) begin
          ref_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          su_cmd.start = 1'b1;
          su_num       = RECIP_NUM;
          su_den       = DIV_D_W'(rnd.val[62:0]);
          state_nxt    = S_RCPW;
        end
      end
      S_RCPW: begin
        if (su_done) begin
          su_cmd.start     = 1'b1;
          su_cmd.sqrt_mode = 1'b1;
          su_num           = su_quo;
          state_nxt        = S_SQW;
        end
      end
      S_SQW: begin
        if (su_done) begin
          r_nxt     = su_root;
          c_nxt     = 2'd0;
          state_nxt = S_SCL;
        end
      end
      S_SCL: begin
        mul_start = 1'b1;
        mul_a     = mag64(bc);
        mul_b     = 64'(r_r);
        state_nxt = S_SCLW;
      end
      S_SCLW: begin
        mul_neg = bc[63];
        if (mul_done) begin
          acc_nxt   = prod_s;
          state_nxt = S_SCLF;
        end
      end
      S_SCLF: begin
        if (rnd.ovf) begin
          ref_nxt   = 1'b1;
          state_nxt = S_OUT;
        end else begin
          res_nxt[c_r] = rnd.val;
          c_nxt        = c_r + 2'd1;
          state_nxt    = (c_r == 2'd3) ? S_OUT : S_SCL;
        end
      end
      S_OUT: begin
        // Wait for the output register to be free before handing over.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= 4'd2;
      loop_en_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KEY_COUNT:   key_count_r <= cfg_data[3:0];
          CFG_LOOP_ENABLE: loop_en_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    t_r    <= t_nxt;
    t0_r   <= t0_nxt;
    lt_r   <= lt_nxt;
    ti_r   <= ti_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    i_r    <= i_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    flip_r <= flip_nxt;
    fneg_r <= fneg_nxt;
    u_r    <= u_nxt;
    acc_r  <= acc_nxt;
    b_r    <= b_nxt;
    r_r    <= r_nxt;
    res_r  <= res_nxt;
    ref_r  <= ref_nxt;
    if (out_load) begin
      out_data_r.refused <= ref_r;
      out_data_r.rot_w   <= ref_r ? 64'sd0 : res_r[0];
      out_data_r.rot_x   <= ref_r ? 64'sd0 : res_r[1];
      out_data_r.rot_y   <= ref_r ? 64'sd0 : res_r[2];
      out_data_r.rot_z   <= ref_r ? 64'sd0 : res_r[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  qks_keystore #(
    .MAX_KEYS (MAX_KEYS),
    .KW       (KW)
  ) u_keystore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (KW'(in_data.key_index)),
    .wr_time (in_data.key_time),
    .wr_rot  ({in_data.key_w, in_data.key_x, in_data.key_y, in_data.key_z}),
    .rd_addr (rd_addr),
    .rd_time (rd_time),
    .rd_rot  (rd_rot)
  );

  qks_shsub u_shsub (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (su_cmd),
    .num   (su_num),
    .den   (su_den),
    .done  (su_done),
    .quo   (su_quo),
    .rem   (su_rem),
    .root  (su_root)
  );

  qks_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

endmodule
